### src/nes_pkg.sv
package nes_pkg;

  localparam int NOTE_SLOTS = 16;
  localparam int SLOT_BITS  = $clog2(NOTE_SLOTS);
  localparam int CNT_BITS   = $clog2(NOTE_SLOTS + 1);
  localparam int TICK_RATE  = 48;
  localparam int OVERSAMPLE = 256;
  localparam int OS_BITS    = $clog2(OVERSAMPLE);
  localparam int ADDR_BITS  = 20;
  localparam int DELAY_CAP  = 7747 * OVERSAMPLE;
  localparam int PEND_BITS  = 21;
  localparam int TICK_BITS  = PEND_BITS - OS_BITS;
  localparam int SPAN_BITS  = 33 - OS_BITS;
  localparam int SAMPLE_RATE = 22050;

  localparam logic [1:0] MODE_DELAY   = 2'd0;
  localparam logic [1:0] MODE_NOTE_ON = 2'd1;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd2;
  localparam logic [1:0] MODE_PROGRAM = 2'd3;

  localparam logic [2:0] SEL_DELAY = 3'd0;
  localparam logic [2:0] SEL_KEY   = 3'd1;
  localparam logic [2:0] SEL_VEL   = 3'd2;
  localparam logic [2:0] SEL_DUR   = 3'd3;
  localparam logic [2:0] SEL_PATCH = 3'd4;

  typedef logic [127:0][3:0] rel_tab_t;

  typedef struct packed {
    logic       load_in;
    logic       emit;
    logic [2:0] sel;
    logic       tick_step;
    logic       key_mark;
    logic       record;
    logic       scan_dec;
    logic       span_load;
    logic       remove;
  } nes_cmd_t;

  typedef struct packed {
    logic tick_zero;
    logic count_zero;
    logic slot_match;
    logic idx_zero;
    logic lower_none;
    logic out_free;
  } nes_stat_t;

  // Release ticks per velocity, rounded to whole ticks.
  function automatic rel_tab_t build_rel();
    rel_tab_t t;
    longint   frm;
    for (int v = 0; v < 128; v++) begin
      frm  = (longint'(128 + v * 32) * TICK_RATE * OVERSAMPLE) / SAMPLE_RATE;
      t[v] = 4'((frm + OVERSAMPLE / 2) / OVERSAMPLE);
    end
    return t;
  endfunction

endpackage

### src/nes_ctrl.sv
module nes_ctrl import nes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [1:0] mode,
  output logic      in_ready,
  input  nes_stat_t stat,
  output nes_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELAY = 3'd1;
  localparam logic [2:0] S_KEY   = 3'd2;
  localparam logic [2:0] S_VEL   = 3'd3;
  localparam logic [2:0] S_DUR   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_PATCH = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (mode == MODE_NOTE_ON) state_next = S_DELAY;
          else if (mode == MODE_NOTE_OFF && !stat.count_zero) state_next = S_SCAN;
        end
      end
      S_DELAY: begin
        if (stat.tick_zero) state_next = S_KEY;
        else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = SEL_DELAY;
          cmd.tick_step = 1'b1;
        end
      end
      S_KEY: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.sel      = SEL_KEY;
          cmd.key_mark = 1'b1;
          state_next   = S_VEL;
        end
      end
      S_VEL: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_VEL;
          state_next = S_DUR;
        end
      end
      S_DUR: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_DUR;
          cmd.record = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.slot_match) begin
          cmd.span_load = 1'b1;
          state_next    = S_PATCH;
        end else if (stat.idx_zero) state_next = S_IDLE;
        else cmd.scan_dec = 1'b1;
      end
      S_PATCH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_PATCH;
          cmd.remove = 1'b1;
          if (stat.idx_zero || stat.lower_none) state_next = S_IDLE;
          else begin
            cmd.scan_dec = 1'b1;
            state_next   = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### src/nes_dp.sv
module nes_dp import nes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           mode,
  input  logic [19:0]          frames,
  input  logic [3:0]           channel,
  input  logic [6:0]           key,
  input  logic [6:0]           velocity,
  input  nes_cmd_t             cmd,
  output nes_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_BITS-1:0] byte_addr,
  output logic [7:0]           byte_value,
  output logic                 is_patch,
  output logic                 overflow,
  output logic                 last
);

  localparam rel_tab_t REL_TAB = build_rel();

  logic [PEND_BITS-1:0] pending;
  logic [31:0]          elapsed;
  logic [31:0]          now_fr;
  logic [ADDR_BITS-1:0] write_pos;
  logic [ADDR_BITS-1:0] key_pos;
  logic [CNT_BITS-1:0]  count;
  logic [TICK_BITS-1:0] ticks;
  logic [SLOT_BITS-1:0] idx;
  logic [SPAN_BITS-1:0] span;
  logic                 ovf;
  logic [3:0]           chan_r;
  logic [6:0]           key_r;
  logic [6:0]           vel_r;
  logic [1:0]           wave [16];

  logic [ADDR_BITS-1:0] s_pos   [NOTE_SLOTS];
  logic [31:0]          s_start [NOTE_SLOTS];
  logic [3:0]           s_chan  [NOTE_SLOTS];
  logic [6:0]           s_key   [NOTE_SLOTS];
  logic [6:0]           s_vel   [NOTE_SLOTS];

  logic [NOTE_SLOTS-1:0] match;
  logic [NOTE_SLOTS-1:0] lower;
  logic [PEND_BITS:0]    dsum;
  logic [TICK_BITS-1:0]  in_ticks;
  logic                  tick_ge;
  logic [32:0]           span_sum;
  logic [SPAN_BITS:0]    dur_sum;
  logic [7:0]            val;

  always_comb begin
    for (int j = 0; j < NOTE_SLOTS; j++) begin
      match[j] = (CNT_BITS'(j) < count) && s_chan[j] == chan_r && s_key[j] == key_r;
      lower[j] = match[j] && (SLOT_BITS'(j) < idx);
    end
  end

  assign dsum     = {1'b0, pending} + (PEND_BITS + 1)'(frames);
  assign in_ticks = pending[PEND_BITS-1:OS_BITS];
  assign tick_ge  = ticks >= TICK_BITS'(8'h7f);
  assign span_sum = {1'b0, now_fr - s_start[idx]} + 33'(OVERSAMPLE / 2);
  assign dur_sum  = {1'b0, span} + (SPAN_BITS + 1)'(REL_TAB[s_vel[idx]]);

  always_comb begin
    unique case (cmd.sel)
      SEL_DELAY: val = tick_ge ? 8'h7f : 8'(ticks);
      SEL_KEY:   val = {1'b1, key_r};
      SEL_VEL:   val = {wave[chan_r], vel_r[6:1]};
      SEL_DUR:   val = 8'h00;
      SEL_PATCH: val = (dur_sum > (SPAN_BITS + 1)'(8'hff)) ? 8'hff : dur_sum[7:0];
      default:   val = 8'h00;
    endcase
  end

  assign stat.tick_zero  = ticks == '0;
  assign stat.count_zero = count == '0;
  assign stat.slot_match = match[idx];
  assign stat.idx_zero   = idx == '0;
  assign stat.lower_none = lower == '0;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= '0;
      elapsed   <= '0;
      write_pos <= '0;
      count     <= '0;
      for (int c = 0; c < 16; c++) wave[c] <= 2'(c);
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load_in) begin
        unique case (mode)
          MODE_DELAY:
            pending <= (dsum > (PEND_BITS + 1)'(DELAY_CAP)) ? PEND_BITS'(DELAY_CAP)
                                                           : dsum[PEND_BITS-1:0];
          MODE_NOTE_ON: begin
            // Move whole ticks out of the pending delay into elapsed time
            pending <= {{TICK_BITS{1'b0}}, pending[OS_BITS-1:0]};
            elapsed <= elapsed + {{(32 - PEND_BITS){1'b0}}, in_ticks, {OS_BITS{1'b0}}};
          end
          MODE_NOTE_OFF: ;
          MODE_PROGRAM: wave[channel] <= key[1:0];
          default: ;
        endcase
      end
      if (cmd.emit) begin
        if (cmd.sel != SEL_PATCH) write_pos <= write_pos + 1'b1;
      end
      if (cmd.record && !ovf) count <= count + 1'b1;
      if (cmd.remove) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      chan_r <= channel;
      key_r  <= key;
      vel_r  <= velocity;
      ticks  <= in_ticks;
      ovf    <= count >= CNT_BITS'(NOTE_SLOTS);
      now_fr <= elapsed + 32'(pending);
      idx    <= SLOT_BITS'(count - 1'b1);
    end
    if (cmd.tick_step) ticks <= tick_ge ? ticks - TICK_BITS'(8'h7f) : '0;
    if (cmd.key_mark) key_pos <= write_pos;
    if (cmd.scan_dec) idx <= idx - 1'b1;
    if (cmd.span_load) span <= span_sum[32:OS_BITS];
    if (cmd.emit) begin
      byte_value <= val;
      is_patch   <= cmd.sel == SEL_PATCH;
      overflow   <= (cmd.sel != SEL_PATCH) && ovf;
      last       <= (cmd.sel == SEL_DUR) || (cmd.sel == SEL_PATCH && lower == '0);
      byte_addr  <= (cmd.sel == SEL_PATCH) ? s_pos[idx] + ADDR_BITS'(2) : write_pos;
    end
    if (cmd.record && !ovf) begin
      s_pos[count[SLOT_BITS-1:0]]   <= key_pos;
      s_start[count[SLOT_BITS-1:0]] <= elapsed;
      s_chan[count[SLOT_BITS-1:0]]  <= chan_r;
      s_key[count[SLOT_BITS-1:0]]   <= key_r;
      s_vel[count[SLOT_BITS-1:0]]   <= vel_r;
    end
    if (cmd.remove) begin
      // Close the gap: every slot above the removed one moves down by one
      for (int j = 0; j < NOTE_SLOTS - 1; j++) begin
        if (SLOT_BITS'(j) >= idx) begin
          s_pos[j]   <= s_pos[j+1];
          s_start[j] <= s_start[j+1];
          s_chan[j]  <= s_chan[j+1];
          s_key[j]   <= s_key[j+1];
          s_vel[j]   <= s_vel[j+1];
        end
      end
    end
  end

endmodule

### src/note_event_song_encoder.sv
// Note event song encoder. One input beat carries a timed note event; the
// block answers with zero or more output beats, each one byte of the song
// buffer and its address. Delay and program change beats give no output. A
// note on flushes the pending whole ticks as delay bytes of at most 0x7f
// (up to 61 of them) and then appends the key, wave/velocity and a zero
// duration byte. A note off walks the sixteen-entry note table from the top
// slot down, one slot a cycle, and for each match patches that note's
// duration byte and closes the gap in the table.
// Output bytes leave through a one-beat output register, and a stalled output
// holds the controller. Input is taken only while the controller is idle.
// The overflow flag marks every byte of a note on that found the table full;
// last marks the final byte caused by an input beat.
module note_event_song_encoder import nes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [19:0]          frames,
  input  logic [3:0]           channel,
  input  logic [6:0]           key,
  input  logic [6:0]           velocity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_BITS-1:0] byte_addr,
  output logic [7:0]           byte_value,
  output logic                 is_patch,
  output logic                 overflow,
  output logic                 last
);

  nes_cmd_t  cmd;
  nes_stat_t stat;

  // Sequence the bytes of each event
  nes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold timing state, the note table and the output register
  nes_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .frames     (frames),
    .channel    (channel),
    .key        (key),
    .velocity   (velocity),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_addr  (byte_addr),
    .byte_value (byte_value),
    .is_patch   (is_patch),
    .overflow   (overflow),
    .last       (last)
  );

endmodule

### verif/tb_note_event_song_encoder.sv
`timescale 1ns / 1ps

module tb_note_event_song_encoder;
  import nes_pkg::*;

  // One byte written into the song buffer, as the output beat carries it.
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           value;
    logic                 patch;
    logic                 ovf;
    logic                 last;
  } song_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           mode = MODE_DELAY;
  logic [19:0]          frames = '0;
  logic [3:0]           channel = '0;
  logic [6:0]           key = '0;
  logic [6:0]           velocity = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_BITS-1:0] byte_addr;
  logic [7:0]           byte_value;
  logic                 is_patch;
  logic                 overflow;
  logic                 last;

  // Song bytes still owed by the block, oldest first.
  song_byte_t song_bytes[$];
  int         mismatches = 0;
  bit         steady = 1'b0;    // set to suppress idling on both sides

  // Encoder image: pending frames, emitted frames, append position, note table.
  logic [31:0]          pend_frames;
  logic [31:0]          done_frames;
  logic [ADDR_BITS-1:0] put_pos;
  int                   live_notes;
  logic [ADDR_BITS-1:0] note_pos   [NOTE_SLOTS];
  logic [31:0]          note_start [NOTE_SLOTS];
  logic [3:0]           note_chan  [NOTE_SLOTS];
  logic [6:0]           note_key   [NOTE_SLOTS];
  logic [6:0]           note_vel   [NOTE_SLOTS];
  logic [1:0]           chan_wave  [16];

  always #2 clk = ~clk;

  note_event_song_encoder u_top (.*);

  function automatic void owe_byte(logic [ADDR_BITS-1:0] a, logic [7:0] v, logic p,
                                   logic o);
    song_bytes.push_back('{addr: a, value: v, patch: p, ovf: o, last: 1'b0});
  endfunction

  // Duration of a held note: rounded ticks held plus release ticks, capped at 0xff.
  function automatic logic [7:0] held_ticks(logic [31:0] start, logic [6:0] vel);
    logic [31:0] span;
    longint      ticks;
    longint      rel;
    span  = done_frames + pend_frames - start;
    ticks = (longint'(span) + OVERSAMPLE / 2) / OVERSAMPLE;
    rel   = ((longint'(32'h100 + (vel << 6)) >> 1) * TICK_RATE * OVERSAMPLE) / SAMPLE_RATE;
    ticks += (rel + OVERSAMPLE / 2) / OVERSAMPLE;
    return (ticks > 255) ? 8'hff : 8'(ticks);
  endfunction

  // Advance the encoder image by one event and queue the bytes it writes.
  function automatic void encode_event(logic [1:0] m, logic [19:0] f, logic [3:0] ch,
                                       logic [6:0] k, logic [6:0] v);
    longint               sum;
    logic [31:0]          ticks;
    logic                 full;
    logic [ADDR_BITS-1:0] at;
    int                   before_n;
    before_n = song_bytes.size();
    case (m)
      MODE_DELAY: begin
        sum = longint'(pend_frames) + f;
        pend_frames = (sum > DELAY_CAP) ? DELAY_CAP : 32'(sum);
      end
      MODE_NOTE_ON: begin
        ticks = pend_frames / OVERSAMPLE;
        full  = live_notes >= NOTE_SLOTS;
        pend_frames -= ticks * OVERSAMPLE;
        done_frames += ticks * OVERSAMPLE;
        while (ticks >= 32'h7f) begin
          owe_byte(put_pos, 8'h7f, 1'b0, full);
          put_pos++;
          ticks -= 32'h7f;
        end
        if (ticks > 0) begin
          owe_byte(put_pos, 8'(ticks), 1'b0, full);
          put_pos++;
        end
        at = put_pos;
        owe_byte(put_pos, {1'b1, k}, 1'b0, full);
        owe_byte(put_pos + 1'b1, {chan_wave[ch], v[6:1]}, 1'b0, full);
        owe_byte(put_pos + 2'd2, 8'h00, 1'b0, full);
        put_pos += 2'd3;
        if (!full) begin
          note_pos[live_notes]   = at;
          note_start[live_notes] = done_frames;
          note_chan[live_notes]  = ch;
          note_key[live_notes]   = k;
          note_vel[live_notes]   = v;
          live_notes++;
        end
      end
      MODE_NOTE_OFF: begin
        // Patch from the top slot down and close each gap.
        for (int i = live_notes - 1; i >= 0; i--) begin
          if (note_chan[i] == ch && note_key[i] == k) begin
            owe_byte(note_pos[i] + 2'd2, held_ticks(note_start[i], note_vel[i]), 1'b1,
                     1'b0);
            for (int j = i; j + 1 < live_notes; j++) begin
              note_pos[j]   = note_pos[j + 1];
              note_start[j] = note_start[j + 1];
              note_chan[j]  = note_chan[j + 1];
              note_key[j]   = note_key[j + 1];
              note_vel[j]   = note_vel[j + 1];
            end
            live_notes--;
          end
        end
      end
      default: chan_wave[ch] = k[1:0];
    endcase
    if (song_bytes.size() > before_n) song_bytes[song_bytes.size() - 1].last = 1'b1;
  endfunction

  // Send one beat, with an optional random gap first; valid stays high after.
  task automatic send_beat(logic [1:0] m, logic [19:0] f, logic [3:0] ch, logic [6:0] k,
                           logic [6:0] v);
    if (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    frames   <= f;
    channel  <= ch;
    key      <= k;
    velocity <= v;
    do @(posedge clk); while (!in_ready);
    encode_event(m, f, ch, k, v);
  endtask

  // Hold off until every owed byte is out, then let a silent note off finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (song_bytes.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  // Check each output beat against the oldest owed byte; randomise ready.
  always @(posedge clk) begin
    song_byte_t got;
    song_byte_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{addr: byte_addr, value: byte_value, patch: is_patch, ovf: overflow,
                last: last};
        if (song_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: addr %0h value %0h patch %0b ovf %0b last %0b",
                     got.addr, got.value, got.patch, got.ovf, got.last);
        end else begin
          want = song_bytes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat mismatch: exp addr %0h value %0h patch %0b ovf %0b last %0b, got addr %0h value %0h patch %0b ovf %0b last %0b",
                       want.addr, want.value, want.patch, want.ovf, want.last,
                       got.addr, got.value, got.patch, got.ovf, got.last);
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 29);
    end
  end

  // Delay saturation, program changes on both end channels, extreme fields.
  task automatic test_extremes();
    send_beat(MODE_DELAY, 20'h00000, 4'd0, 7'd0, 7'd0);
    send_beat(MODE_DELAY, 20'hfffff, 4'd15, 7'd127, 7'd127);
    send_beat(MODE_DELAY, 20'hfffff, 4'd0, 7'd0, 7'd0);
    send_beat(MODE_NOTE_ON, 20'd0, 4'd0, 7'd127, 7'd127);
    send_beat(MODE_PROGRAM, 20'd0, 4'd15, 7'd127, 7'd0);
    send_beat(MODE_PROGRAM, 20'd0, 4'd0, 7'd0, 7'd0);
    send_beat(MODE_DELAY, 20'd300, 4'd0, 7'd0, 7'd0);
    send_beat(MODE_NOTE_ON, 20'd0, 4'd15, 7'd0, 7'd0);
    send_beat(MODE_NOTE_ON, 20'd0, 4'd0, 7'd127, 7'd1);
    drain();
  endtask

  // Unmatched note off, a double match, and a note held past the duration cap.
  task automatic test_note_off();
    send_beat(MODE_NOTE_OFF, 20'd0, 4'd3, 7'd5, 7'd0);
    send_beat(MODE_NOTE_OFF, 20'd0, 4'd0, 7'd127, 7'd0);
    send_beat(MODE_NOTE_OFF, 20'd0, 4'd15, 7'd0, 7'd0);
    send_beat(MODE_NOTE_ON, 20'd0, 4'd5, 7'd64, 7'd90);
    send_beat(MODE_DELAY, 20'd1000, 4'd0, 7'd0, 7'd0);
    send_beat(MODE_NOTE_ON, 20'd0, 4'd5, 7'd64, 7'd20);
    send_beat(MODE_NOTE_OFF, 20'd0, 4'd5, 7'd64, 7'd0);
    send_beat(MODE_NOTE_ON, 20'd0, 4'd9, 7'd33, 7'd127);
    send_beat(MODE_DELAY, 20'hfffff, 4'd0, 7'd0, 7'd0);
    send_beat(MODE_NOTE_OFF, 20'd0, 4'd9, 7'd33, 7'd0);
    send_beat(MODE_NOTE_OFF, 20'd0, 4'd0, 7'd127, 7'd0);
    drain();
  endtask

  // Fill the table, overflow it, then release in groups of matching keys.
  task automatic test_full_table();
    for (int i = 0; i <= NOTE_SLOTS; i++)
      send_beat(MODE_NOTE_ON, 20'd0, 4'd1, 7'(i % 4), 7'($urandom_range(127)));
    for (int i = 0; i < 4; i++) begin
      send_beat(MODE_DELAY, 20'($urandom_range(2000)), 4'd0, 7'd0, 7'd0);
      send_beat(MODE_NOTE_OFF, 20'd0, 4'd1, 7'(i), 7'd0);
    end
    drain();
  endtask

  // Mostly well-formed note traffic with random content, some noise.
  task automatic test_random_song();
    int          pick;
    int          s;
    logic [19:0] f;
    for (int n = 0; n < 55; n++) begin
      steady = (n >= 20 && n < 35);
      if (n == 40) drain();
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_beat(MODE_NOTE_ON, 20'd0, 4'($urandom), 7'($urandom), 7'($urandom));
      end else if (pick < 65 && live_notes > 0) begin
        s = $urandom_range(live_notes - 1);
        send_beat(MODE_NOTE_OFF, 20'($urandom), note_chan[s], note_key[s], 7'($urandom));
      end else if (pick < 85) begin
        f = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(3000));
        send_beat(MODE_DELAY, f, 4'($urandom), 7'($urandom), 7'($urandom));
      end else if (pick < 93) begin
        send_beat(MODE_PROGRAM, 20'($urandom), 4'($urandom), 7'($urandom), 7'($urandom));
      end else begin
        send_beat(MODE_NOTE_OFF, 20'($urandom), 4'($urandom), 7'($urandom),
                  7'($urandom));
      end
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin
    pend_frames = '0;
    done_frames = '0;
    put_pos     = '0;
    live_notes  = 0;
    for (int c = 0; c < 16; c++) chan_wave[c] = 2'(c);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_note_off();
    test_full_table();
    test_random_song();
    if (mismatches == 0 && song_bytes.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Give up well beyond the slowest legal run.
  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
